// ===== rtl/sptt_pkg.sv =====
package sptt_pkg;

  typedef enum logic [1:0] {
    CMD_ATTACH   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_EVALUATE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DEGREE,
    ST_TERM,
    ST_POWER,
    ST_PROD,
    ST_ACCUM,
    ST_RESULT,
    ST_HOLD
  } state_t;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = -48'sh8000_0000_0000;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic scan_clr;   // index := 0, clear found
    logic scan_step;  // compare entry at index, advance
    logic decide;     // latch accept/reject of the command
    logic append;     // write new term at count
    logic shift_clr;  // index := found index
    logic shift_step; // move entry index+1 down to index
    logic count_dec;
    logic deg_clr;
    logic deg_step;   // fold entry at index into degree
    logic term_start; // power := 1.0, k := 0
    logic pow_step;   // power := power * x
    logic prod_step;  // product := power * coef
    logic accum;      // sum += product, index++
    logic res_load;   // form result register
  } cmd_bus_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic scan_done;
    logic found;
    logic full;
    logic attach_bad;
    logic remove_bad;
    logic shift_done;
    logic deg_done;
    logic terms_done;
    logic pow_done;
  } stat_bus_t;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [47:0] r;
    begin
      p = a * b;
      r = p[63:16];
      if (r > 48'sh0000_7FFF_FFFF) qmul = 32'sh7FFF_FFFF;
      else if (r < -48'sh0000_8000_0000) qmul = -32'sh8000_0000;
      else qmul = r[31:0];
    end
  endfunction

endpackage

// ===== rtl/sptt_ram.sv =====
module sptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sptt_ctrl.sv =====
module sptt_ctrl
  import sptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  stat_bus_t st,
  output cmd_bus_t  cb,
  output logic      busy,
  output logic      res_valid
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cb = '0;
    state_next = state;
    busy = (state != ST_IDLE);
    res_valid = (state == ST_HOLD);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cb.load = 1'b1;
          cb.scan_clr = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.cmd == CMD_EVALUATE) begin
          state_next = ST_TERM;
        end else if (st.scan_done) begin
          state_next = ST_DECIDE;
        end else begin
          cb.scan_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        cb.decide = 1'b1;
        state_next = ST_RESULT;
        case (st.cmd)
          CMD_ATTACH: if (!st.attach_bad) cb.append = 1'b1;
          CMD_REMOVE: if (!st.remove_bad) begin
            cb.shift_clr = 1'b1;
            state_next = ST_SHIFT;
          end
          default: ;
        endcase
      end
      ST_SHIFT: begin
        if (st.shift_done) begin
          cb.count_dec = 1'b1;
          cb.deg_clr = 1'b1;
          state_next = ST_DEGREE;
        end else begin
          cb.shift_step = 1'b1;
        end
      end
      ST_DEGREE: begin
        if (st.deg_done) state_next = ST_RESULT;
        else cb.deg_step = 1'b1;
      end
      ST_TERM: begin
        if (st.terms_done) begin
          state_next = ST_RESULT;
        end else begin
          cb.term_start = 1'b1;
          state_next = ST_POWER;
        end
      end
      ST_POWER: begin
        if (st.pow_done) state_next = ST_PROD;
        else cb.pow_step = 1'b1;
      end
      ST_PROD: begin
        cb.prod_step = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cb.accum = 1'b1;
        state_next = ST_TERM;
      end
      ST_RESULT: begin
        cb.res_load = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/sptt_dp.sv =====
module sptt_dp
  import sptt_pkg::*;
#(
  parameter int MAX_TERMS    = 16,
  parameter int MAX_EXPONENT = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_bus_t    cb,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_exponent,
  input  logic [31:0] in_coefficient,
  input  logic [31:0] in_point,
  output stat_bus_t   st,
  output logic [95:0] res
);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  cmd_t               cmd;
  logic [7:0]         exp_r;
  logic signed [31:0] coef_r;
  logic signed [31:0] x_r;
  logic [CW-1:0]      count_held;
  logic [7:0]         highest;
  logic [CW-1:0]      idx;
  logic               rd_pend;     // RAM read of idx in flight
  logic               found;
  logic [IW-1:0]      found_idx;
  logic signed [31:0] found_coef;
  logic signed [31:0] pw;
  logic signed [31:0] prod;
  logic [7:0]         k;
  logic signed [47:0] sum;
  logic               rej;         // command rejected, fixed at decision

  logic [7:0]  ex_rd;
  logic [31:0] co_rd;
  logic        we;
  logic [IW-1:0] waddr, raddr;
  logic [7:0]  ex_wd;
  logic [31:0] co_wd;
  logic [CW-1:0] idx_p1;
  logic signed [48:0] sum_w;

  assign idx_p1 = idx + 1'b1;
  // read address: entry idx, or idx+1 while shifting
  assign raddr = cb.shift_step ? idx_p1[IW-1:0] : idx[IW-1:0];

  always_comb begin
    we = 1'b0; waddr = count_held[IW-1:0]; ex_wd = exp_r; co_wd = coef_r;
    if (cb.append) we = 1'b1;
    if (cb.shift_step && rd_pend) begin
      we = 1'b1; waddr = idx[IW-1:0]; ex_wd = ex_rd; co_wd = co_rd;
    end
  end

  sptt_ram #(.WIDTH(8), .DEPTH(MAX_TERMS)) u_ex (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ex_wd), .raddr(raddr), .rdata(ex_rd));
  sptt_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_co (
    .clk(clk), .we(we), .waddr(waddr), .wdata(co_wd), .raddr(raddr), .rdata(co_rd));

  assign sum_w = {sum[47], sum} + {{17{prod[31]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      count_held <= '0;
      highest    <= '0;
      rd_pend    <= 1'b0;
    end else begin
      if (cb.append) begin
        count_held <= count_held + 1'b1;
        if (exp_r > highest) highest <= exp_r;
      end
      if (cb.count_dec) count_held <= count_held - 1'b1;
      // degree rebuilt from scratch after a removal
      if (cb.deg_clr) highest <= '0;
      if (cb.deg_step && rd_pend && ex_rd > highest) highest <= ex_rd;
      // RAM read data is registered: alternate issue and use
      if (cb.scan_step || cb.shift_step || cb.deg_step || cb.pow_step)
        rd_pend <= ~rd_pend;
      else
        rd_pend <= 1'b0;
    end
    if (cb.load) begin
      cmd <= cmd_t'(in_command); exp_r <= in_exponent;
      coef_r <= in_coefficient; x_r <= in_point;
      sum <= '0; rej <= 1'b0;
    end
    if (cb.decide)
      rej <= (cmd == CMD_ATTACH) ? st.attach_bad :
             (cmd == CMD_REMOVE) ? st.remove_bad : 1'b0;
    if (cb.scan_clr) begin
      idx <= '0; found <= 1'b0; found_idx <= '0; found_coef <= '0;
    end
    if (cb.scan_step && rd_pend) begin
      if (!found && ex_rd == exp_r) begin
        found <= 1'b1; found_idx <= idx[IW-1:0]; found_coef <= co_rd;
      end
      idx <= idx_p1;
    end
    if (cb.shift_clr) idx <= CW'(found_idx);
    if (cb.shift_step && rd_pend) idx <= idx_p1;
    if (cb.deg_clr) idx <= '0;
    if (cb.deg_step && rd_pend) idx <= idx_p1;
    if (cb.term_start) begin
      pw <= Q_ONE; k <= '0;
    end
    if (cb.pow_step && rd_pend && k < ex_rd) begin
      pw <= qmul(pw, x_r); k <= k + 1'b1;
    end
    if (cb.prod_step) prod <= qmul(pw, co_rd);
    if (cb.accum) begin
      if (sum_w > $signed({S48_MAX[47], S48_MAX})) sum <= S48_MAX;
      else if (sum_w < $signed({S48_MIN[47], S48_MIN})) sum <= S48_MIN;
      else sum <= sum_w[47:0];
      idx <= idx_p1;
    end
    if (cb.res_load) begin
      res[0]     <= rej;
      res[32:1]  <= (cmd == CMD_QUERY && found) ? found_coef : 32'd0;
      res[40:33] <= highest;
      res[45:41] <= 5'(count_held);
      res[93:46] <= (cmd == CMD_EVALUATE) ? sum : 48'd0;
      res[95:94] <= '0;
    end
  end

  assign st.cmd        = cmd;
  assign st.scan_done  = (idx >= count_held);
  assign st.found      = found;
  assign st.full       = (count_held >= CW'(MAX_TERMS));
  assign st.attach_bad = (coef_r == 32'sd0) || (32'(exp_r) > MAX_EXPONENT) || found
                         || st.full;
  assign st.remove_bad = (exp_r > highest) || !found;
  assign st.shift_done = (idx_p1 >= count_held);
  assign st.deg_done   = (idx >= count_held);
  assign st.terms_done = (idx >= count_held);
  assign st.pow_done   = rd_pend && (k >= ex_rd);
endmodule

// ===== rtl/sparse_polynomial_term_table.sv =====
// Sparse polynomial term table: holds up to MAX_TERMS (exponent, coefficient)
// terms in insertion order and serves attach, remove, query and evaluate
// commands, one result transaction per command transaction. One command is
// worked at a time; s_tready is high only while idle. Attach, remove and
// query make a linear scan of the term RAMs; an accepted remove then adds a
// shift-down and a degree pass. Evaluate skips the scan and steps each term's
// power one exponent at a time through a Q16.16 multiply. The result is held
// in an output register until m_tready takes it. Q16.16 products floor and
// saturate to 32 bits; the sum saturates to 48 bits (Q32.16).
module sparse_polynomial_term_table
  import sptt_pkg::*;
#(
  parameter int MAX_TERMS    = 16,
  parameter int MAX_EXPONENT = 255
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0], term_exponent[9:2], coefficient[41:10], point[73:42], zero pad
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[0], coefficient_out[32:1], degree[40:33], term_count[45:41],
  // value[93:46], zero pad
  output logic [95:0]  m_tdata
);
  cmd_bus_t  cb;
  stat_bus_t st;
  logic      busy;
  logic      in_fire, out_fire;
  logic [95:0] res;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = res;

  sptt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .st(st), .cb(cb), .busy(busy), .res_valid(m_tvalid));

  sptt_dp #(.MAX_TERMS(MAX_TERMS), .MAX_EXPONENT(MAX_EXPONENT)) u_dp (
    .clk(clk), .rst(rst), .cb(cb),
    .in_command(s_tdata[1:0]), .in_exponent(s_tdata[9:2]),
    .in_coefficient(s_tdata[41:10]), .in_point(s_tdata[73:42]),
    .st(st), .res(res));
endmodule

// ===== rtl/sptt_checker.sv =====
module sptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);
  // never take a command while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // term count never exceeds table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[45:41] <= 5'd16) else $error("count out of range");
  // a rejected command yields no value
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[93:46] == 48'd0) else $error("value on reject");
endmodule

bind sparse_polynomial_term_table sptt_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

// ===== tb/sv/sparse_polynomial_term_table_checker.sv =====
module sparse_polynomial_term_table_checker
  import sptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  output int          fail_count,
  output int          pending
);

  localparam int TABLE_DEPTH = 16;
  localparam int TOP_EXP     = 255;

  typedef struct packed {
    logic        status;
    logic [31:0] coef;
    logic [7:0]  degree;
    logic [4:0]  count;
    logic [47:0] value;
  } poly_result_t;

  logic [7:0]         held_exp [TABLE_DEPTH];
  logic signed [31:0] held_coef[TABLE_DEPTH];
  int                 held_n;
  logic [7:0]         held_deg;
  poly_result_t       awaited[$];

  // floor the Q16.16 product, clamp to 32 bits
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = p >>> 16;
    if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic int locate(logic [7:0] e);
    for (int i = 0; i < held_n; i++)
      if (held_exp[i] == e) return i;
    return -1;
  endfunction

  function automatic poly_result_t apply_command(logic [79:0] d);
    cmd_t               op;
    logic [7:0]         e;
    logic signed [31:0] c;
    logic signed [31:0] x;
    logic signed [31:0] pw;
    logic signed [63:0] sum;
    poly_result_t       r;
    int                 idx;
    op  = cmd_t'(d[1:0]);
    e   = d[9:2];
    c   = d[41:10];
    x   = d[73:42];
    r   = '0;
    sum = 0;
    case (op)
      CMD_ATTACH: begin
        if (c == 0 || e > TOP_EXP || locate(e) >= 0 || held_n >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          held_exp[held_n]  = e;
          held_coef[held_n] = c;
          held_n++;
          if (e > held_deg) held_deg = e;
        end
      end
      CMD_REMOVE: begin
        idx = (e > held_deg) ? -1 : locate(e);
        if (idx < 0) begin
          r.status = 1'b1;
        end else begin
          for (int i = idx; i + 1 < held_n; i++) begin
            held_exp[i]  = held_exp[i+1];
            held_coef[i] = held_coef[i+1];
          end
          held_n--;
          held_deg = 0;
          for (int i = 0; i < held_n; i++)
            if (held_exp[i] > held_deg) held_deg = held_exp[i];
        end
      end
      CMD_QUERY: begin
        idx = locate(e);
        if (idx >= 0) r.coef = held_coef[idx];
      end
      default: begin
        for (int i = 0; i < held_n; i++) begin
          pw = 32'sh0001_0000;
          for (int k = 0; k < held_exp[i]; k++) pw = fx_mul(pw, x);
          sum += 64'(fx_mul(pw, held_coef[i]));
          if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
          if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
        end
        r.value = sum[47:0];
      end
    endcase
    r.degree = held_deg;
    r.count  = 5'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin
    poly_result_t got;
    poly_result_t exp_r;
    if (rst) begin
      held_n     <= 0;
      held_deg   <= '0;
      fail_count <= 0;
      awaited.delete();
    end else begin
      if (s_tvalid && s_tready) awaited.push_back(apply_command(s_tdata));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[0], m_tdata[32:1], m_tdata[40:33], m_tdata[45:41], m_tdata[93:46]};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = awaited.pop_front();
          if (got.status !== exp_r.status || got.coef !== exp_r.coef ||
              got.degree !== exp_r.degree || got.count !== exp_r.count ||
              got.value !== exp_r.value) begin
            $display("%0t: status/coef/degree/count/value expected %0d/%h/%0d/%0d/%h actual %0d/%h/%0d/%0d/%h",
                     $time, exp_r.status, exp_r.coef, exp_r.degree, exp_r.count, exp_r.value,
                     got.status, got.coef, got.degree, got.count, got.value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

// ===== tb/sv/sparse_polynomial_term_table_tb.sv =====
module sparse_polynomial_term_table_tb;
  import sptt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // command, term_exponent, coefficient, point, pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // status, coefficient_out, degree, term_count, value, pad
  int          fail_count;
  int          pending;
  int          gap_left;

  always #10 clk = ~clk;

  sparse_polynomial_term_table uut (.*);

  sparse_polynomial_term_table_checker chk (.*);

  // receiver back-pressure: alternating runs of ready and stall
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk) m_tready <= 1'b1;
      run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (run) @(posedge clk) m_tready <= 1'b0;
    end
  end

  // one command transaction; gaps come in bursts
  task automatic send(cmd_t op, logic [7:0] e, logic [31:0] c, logic [31:0] x);
    if (gap_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk) s_tvalid <= 1'b0;
      gap_left = $urandom_range(1, 8);
    end
    gap_left--;
    @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, x, c, e, op};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 1'b0;
  endtask

  // small |x| keeps high powers interesting; big ones drive saturation
  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  initial begin
    logic [7:0] e;
    gap_left = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: empty table, zero coef, extremes, duplicate, full table
    send(CMD_EVALUATE, 8'd0, 32'd0, 32'h0002_0000);
    send(CMD_REMOVE, 8'd0, 32'd0, 32'd0);
    send(CMD_ATTACH, 8'd3, 32'd0, 32'd0);
    send(CMD_ATTACH, 8'd0, 32'h8000_0000, 32'd0);
    send(CMD_ATTACH, 8'd255, 32'h7FFF_FFFF, 32'd0);
    send(CMD_ATTACH, 8'd255, 32'h0001_0000, 32'd0);
    send(CMD_QUERY, 8'd255, 32'd0, 32'd0);
    send(CMD_QUERY, 8'd7, 32'd0, 32'd0);
    send(CMD_EVALUATE, 8'd0, 32'd0, 32'h7FFF_FFFF);
    send(CMD_EVALUATE, 8'd0, 32'd0, 32'h8000_0000);
    send(CMD_EVALUATE, 8'd0, 32'd0, 32'hFFFF_FFFF);
    for (int i = 1; i <= 14; i++)
      send(CMD_ATTACH, 8'(i * 17 % 250 + 1), 32'h7FFF_FFFF, 32'd0);
    send(CMD_ATTACH, 8'd254, 32'd5, 32'd0);   // table full
    send(CMD_EVALUATE, 8'd0, 32'd0, 32'h0000_8000);
    send(CMD_REMOVE, 8'd255, 32'd0, 32'd0);
    send(CMD_REMOVE, 8'd0, 32'd0, 32'd0);
    send(CMD_REMOVE, 8'd200, 32'd0, 32'd0);    // below degree, absent
    // random: mixed operations, exponents half the time drawn from 0..15
    repeat (110) begin
      e = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(CMD_ATTACH, e, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom, $urandom);
        4, 5, 6:    send(CMD_REMOVE, e, $urandom, $urandom);
        7:          send(CMD_QUERY, e, $urandom, $urandom);
        default:    send(CMD_EVALUATE, e, $urandom, pick_point());
      endcase
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sparse_polynomial_term_table.f =====
rtl/sptt_pkg.sv
rtl/sptt_ram.sv
rtl/sptt_ctrl.sv
rtl/sptt_dp.sv
rtl/sparse_polynomial_term_table.sv
rtl/sptt_checker.sv
tb/sv/sparse_polynomial_term_table_checker.sv
tb/sv/sparse_polynomial_term_table_tb.sv
